### src/tqla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqla_pkg
// Shared types and constants of the tabular Q-learning agent core.
// ----------------------------------------------------------------------------
package tqla_pkg;

  localparam int STATE_BITS  = 8;
  localparam int ACTION_BITS = 4;
  localparam int ADDR_BITS   = STATE_BITS + ACTION_BITS;
  localparam int ACTION_CNT  = 1 << ACTION_BITS;

  localparam logic [1:0] FUNC_ACT     = 2'd0;
  localparam logic [1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_GAMMA   = 3'd1;
  localparam logic [2:0] REG_EPSILON = 3'd2;
  localparam logic [2:0] REG_ACTIONS = 3'd3;
  localparam logic [2:0] REG_LEARN   = 3'd4;
  localparam logic [2:0] REG_INIT    = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_MOD,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_MUL_G,
    ST_MUL_A,
    ST_OLD_WAIT,
    ST_WRITE,
    ST_FINAL,
    ST_FINAL_WAIT,
    ST_DONE
  } state_t;

  // floor((a * f) / 2^16) for a Q0.16 fraction f
  function automatic logic signed [49:0] frac_mul(input logic signed [33:0] a,
                                                 input logic [15:0] f);
    logic signed [50:0] p;
    p = 51'(a) * 51'($signed({1'b0, f}));
    return 50'($signed(p[50:16]));
  endfunction

endpackage
`default_nettype wire

### src/tabular_q_learning_agent_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_core
// Q-learning agent: value table in block memory, one compare and one
// multiplier shared under a small sequencer.
// ----------------------------------------------------------------------------
// channel | dir | tdata / fields
// in_     | in  | func, reward, next_state, rand_draw, rand_pick
// out_    | out | action, best_action, explored, new_value, state_now
// cfg_    | in  | cfg_index (3b), cfg_data (32b)
// Act: one argmax scan over actions_in_use when greedy, after a 16-step
// remainder when exploring; update: two scans, or one with learning off;
// restart: a table fill and one scan, the fill writing one table entry per
// cycle through the single write port.
// rst_n is synchronous; the table itself is not reset.
// Ready only when idle; a finished result holds the sequencer in DONE while
// the previous one is still unaccepted in out_.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [1:0] func, [33:2] reward, [41:34] next_state, [57:42] rand_draw,
  // [73:58] rand_pick, [79:74] zero
  input  wire logic [79:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [3:0] action, [7:4] best_action, [8] explored, [40:9] new_value,
  // [48:41] state_now, [55:49] zero
  output logic [55:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int AB = tqla_pkg::ACTION_BITS;
  localparam int SB = tqla_pkg::STATE_BITS;

  logic [15:0] alpha_r, gamma_r, eps_r;
  logic [4:0]  nact_r;
  logic        learn_r;
  logic [31:0] init_r;
  logic [SB-1:0] start_r;

  tqla_pkg::state_t st_r, st_nxt;

  logic [1:0]  func_r;
  logic signed [31:0] reward_r;
  logic [SB-1:0] next_r, cur_r;
  logic [15:0] pick_r;
  logic [3:0]  rem_r;
  logic        explore_r;
  logic [AB-1:0] last_r, action_r;
  logic [tqla_pkg::ADDR_BITS:0] cnt_r;
  logic [AB-1:0] bidx_r;
  logic signed [31:0] bval_r;
  logic signed [31:0] old_r;
  logic signed [33:0] tgt_r;
  logic signed [31:0] newv_r;
  logic [55:0] odata_r;
  logic        ovalid_r;

  logic [4:0]  n_eff;
  assign n_eff = (nact_r == 5'd0) ? 5'd1 :
                 (nact_r > 5'(tqla_pkg::ACTION_CNT)) ? 5'(tqla_pkg::ACTION_CNT) : nact_r;

  // table memory, registered read
  logic [31:0] mem [0:(1<<tqla_pkg::ADDR_BITS)-1];
  logic [tqla_pkg::ADDR_BITS-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic done_go;
  assign done_go = (st_r == tqla_pkg::ST_DONE) && (!ovalid_r || out_tready);

  assign in_tready  = (st_r == tqla_pkg::ST_IDLE);
  assign cfg_ready  = (st_r == tqla_pkg::ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // scan state selects which row the argmax walks
  logic [SB-1:0] scan_state;
  assign scan_state = (st_r == tqla_pkg::ST_SCAN || st_r == tqla_pkg::ST_SCAN_WAIT) ?
                      next_r : cur_r;

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic [15:0]        mul_f;
  logic signed [49:0] mul_p;
  assign mul_a = (st_r == tqla_pkg::ST_MUL_G) ? 34'(bval_r) : (tgt_r - 34'(old_r));
  assign mul_f = (st_r == tqla_pkg::ST_MUL_G) ? gamma_r : alpha_r;
  assign mul_p = tqla_pkg::frac_mul(mul_a, mul_f);

  logic signed [49:0] sum;
  assign sum = (st_r == tqla_pkg::ST_MUL_G) ? (mul_p + 50'(reward_r)) : (mul_p + 50'(old_r));

  // restoring remainder step, one pick bit a cycle from the top
  logic [4:0] rem_sh, rem_step;
  assign rem_sh   = {rem_r, pick_r[15]};
  assign rem_step = (rem_sh >= n_eff) ? (rem_sh - n_eff) : rem_sh;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tqla_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (in_tdata[1:0])
            tqla_pkg::FUNC_ACT:     st_nxt = tqla_pkg::ST_MOD;
            tqla_pkg::FUNC_UPDATE:  st_nxt = learn_r ? tqla_pkg::ST_SCAN : tqla_pkg::ST_MUL_G;
            tqla_pkg::FUNC_RESTART: st_nxt = tqla_pkg::ST_FILL;
            default:                st_nxt = tqla_pkg::ST_FINAL;
          endcase
        end
      end
      tqla_pkg::ST_FILL:
        if (cnt_r == (tqla_pkg::ADDR_BITS+1)'((1<<tqla_pkg::ADDR_BITS) - 1))
          st_nxt = tqla_pkg::ST_FINAL;
      tqla_pkg::ST_MOD:
        if (!explore_r || cnt_r[3:0] == 4'd15)
          st_nxt = tqla_pkg::ST_FINAL;
      tqla_pkg::ST_SCAN:      if (cnt_r[AB:0] == (AB+1)'(n_eff)) st_nxt = tqla_pkg::ST_SCAN_WAIT;
      tqla_pkg::ST_SCAN_WAIT: st_nxt = tqla_pkg::ST_MUL_G;
      tqla_pkg::ST_MUL_G:     st_nxt = tqla_pkg::ST_OLD_WAIT;
      tqla_pkg::ST_OLD_WAIT:  st_nxt = learn_r ? tqla_pkg::ST_MUL_A : tqla_pkg::ST_WRITE;
      tqla_pkg::ST_MUL_A:     st_nxt = tqla_pkg::ST_WRITE;
      tqla_pkg::ST_WRITE:     st_nxt = tqla_pkg::ST_FINAL;
      tqla_pkg::ST_FINAL:     if (cnt_r[AB:0] == (AB+1)'(n_eff)) st_nxt = tqla_pkg::ST_FINAL_WAIT;
      tqla_pkg::ST_FINAL_WAIT: st_nxt = tqla_pkg::ST_DONE;
      tqla_pkg::ST_DONE:      if (done_go) st_nxt = tqla_pkg::ST_IDLE;
      default:                st_nxt = tqla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[tqla_pkg::ADDR_BITS-1:0];
    wdata = init_r;
    raddr = {scan_state, cnt_r[AB-1:0]};
    case (st_r)
      tqla_pkg::ST_FILL:  we = 1'b1;
      tqla_pkg::ST_MUL_G, tqla_pkg::ST_OLD_WAIT: raddr = {cur_r, last_r};
      tqla_pkg::ST_WRITE: begin
        we    = learn_r && (func_r == tqla_pkg::FUNC_UPDATE);
        waddr = {cur_r, last_r};
        wdata = newv_r;
      end
      default: ;
    endcase
  end

  // argmax step: data for entry cnt-1 arrives the cycle after its address
  logic cmp_on;
  assign cmp_on = (st_r == tqla_pkg::ST_SCAN || st_r == tqla_pkg::ST_FINAL) &&
                  (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tqla_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      cur_r <= '0;
      last_r <= '0;
      alpha_r <= 16'd6554; gamma_r <= 16'd58982; eps_r <= 16'd6554;
      nact_r <= 5'd16; learn_r <= 1'b1; init_r <= '0; start_r <= '0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (done_go) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tqla_pkg::REG_ALPHA:   alpha_r <= cfg_data[15:0];
          tqla_pkg::REG_GAMMA:   gamma_r <= cfg_data[15:0];
          tqla_pkg::REG_EPSILON: eps_r   <= cfg_data[15:0];
          tqla_pkg::REG_ACTIONS: nact_r  <= cfg_data[4:0];
          tqla_pkg::REG_LEARN:   learn_r <= cfg_data[0];
          tqla_pkg::REG_INIT:    init_r  <= cfg_data;
          tqla_pkg::REG_START:   start_r <= cfg_data[SB-1:0];
          default: ;
        endcase
      end
      case (st_r)
        tqla_pkg::ST_IDLE: cnt_r <= '0;
        tqla_pkg::ST_FILL: begin
          if (st_nxt == tqla_pkg::ST_FINAL) begin
            cnt_r <= '0;
            cur_r <= start_r;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        tqla_pkg::ST_MOD, tqla_pkg::ST_SCAN, tqla_pkg::ST_FINAL:
          if (st_r != st_nxt) cnt_r <= '0; else cnt_r <= cnt_r + 1'b1;
        tqla_pkg::ST_WRITE: begin
          cnt_r <= '0;
          if (func_r == tqla_pkg::FUNC_UPDATE) cur_r <= next_r;
        end
        tqla_pkg::ST_DONE: begin
          if (done_go && func_r == tqla_pkg::FUNC_ACT)
            last_r <= explore_r ? action_r : bidx_r;
        end
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (st_r == tqla_pkg::ST_IDLE && in_tvalid && in_tready) begin
      func_r    <= in_tdata[1:0];
      reward_r  <= in_tdata[33:2];
      next_r    <= in_tdata[41:34];
      explore_r <= (in_tdata[1:0] == tqla_pkg::FUNC_ACT) && (in_tdata[57:42] < eps_r);
      pick_r    <= in_tdata[73:58];
      rem_r     <= '0;
      newv_r    <= '0;
      action_r  <= '0;
    end
    if (st_r == tqla_pkg::ST_MOD && explore_r) begin
      pick_r <= {pick_r[14:0], 1'b0};
      rem_r  <= rem_step[3:0];
      if (cnt_r[3:0] == 4'd15) action_r <= rem_step[AB-1:0];
    end
    if (cmp_on) begin
      if (cnt_r[AB:0] == (AB+1)'(1) || $signed(rdata_r) > bval_r) begin
        bval_r <= rdata_r;
        bidx_r <= cnt_r[AB-1:0] - 1'b1;
      end
    end else if (st_r == tqla_pkg::ST_SCAN || st_r == tqla_pkg::ST_FINAL) begin
      bidx_r <= '0;
    end
    if (st_r == tqla_pkg::ST_MUL_G) tgt_r <= sum[33:0];
    if (st_r == tqla_pkg::ST_OLD_WAIT) begin
      old_r  <= rdata_r;
      newv_r <= rdata_r;
    end
    if (st_r == tqla_pkg::ST_MUL_A) begin
      if (sum > 50'sd2147483647)       newv_r <= 32'h7fffffff;
      else if (sum < -50'sd2147483648) newv_r <= 32'h80000000;
      else                              newv_r <= sum[31:0];
    end
    if (done_go)
      odata_r <= {7'd0, cur_r, newv_r, explore_r, bidx_r,
                  (func_r == tqla_pkg::FUNC_ACT) ? (explore_r ? action_r : bidx_r) : 4'd0};
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (!rst_n)
    we |-> st_r == tqla_pkg::ST_FILL || st_r == tqla_pkg::ST_WRITE)
    else $error("stray table write");

endmodule
`default_nettype wire

### bench/tabular_q_learning_agent_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_core_tb
// Drives act, update, restart and unused requests into the agent under a
// range of register settings. Every result is checked against a built-in
// predictor of the value table, the epsilon-greedy choice and the update.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int TABLE_SIZE  = 256 * tqla_pkg::ACTION_CNT;

  typedef struct packed {
    logic [15:0] pick;
    logic [15:0] draw;
    logic [7:0]  nxt;
    logic [31:0] reward;
    logic [1:0]  func;
  } request_t;

  typedef struct packed {
    logic [7:0]  state_now;
    logic [31:0] new_value;
    logic        explored;
    logic [3:0]  best_action;
    logic [3:0]  action;
  } agent_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  tabular_q_learning_agent_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic signed [31:0] q_table [TABLE_SIZE];
  logic [7:0]  cur_state;
  logic [3:0]  last_act;
  logic [15:0] alpha, gamma, epsilon;
  logic [4:0]  actions_used;
  logic        learn_en;
  logic [31:0] fill_value;
  logic [7:0]  start_st;

  agent_result_t expected_results[$];
  int errors = 0;
  bit no_idle = 0;
  int hold_cycles = 0;
  int stall_count = 0;

  function automatic int unsigned eff_actions();
    if (actions_used == 0) return 1;
    if (actions_used > tqla_pkg::ACTION_CNT) return tqla_pkg::ACTION_CNT;
    return actions_used;
  endfunction

  // lowest-index maximum over the used actions of state s
  function automatic logic [3:0] greedy_action(logic [7:0] s, output longint best);
    logic [3:0] idx;
    idx = 0;
    best = longint'(q_table[{s, 4'd0}]);
    for (int a = 1; a < eff_actions(); a++) begin
      if (longint'(q_table[{s, a[3:0]}]) > best) begin
        best = longint'(q_table[{s, a[3:0]}]);
        idx = a[3:0];
      end
    end
    return idx;
  endfunction

  function automatic longint scale_frac(longint a, logic [15:0] f);
    longint p;
    p = a * longint'({48'd0, f});
    return p >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_step(request_t r);
    agent_result_t res;
    longint old_v, best_next, target, nv;
    logic [11:0] pos;
    res = '0;
    case (r.func)
      tqla_pkg::FUNC_ACT: begin
        if (r.draw < epsilon) begin
          res.action = 4'(r.pick % eff_actions());
          res.explored = 1'b1;
        end else begin
          res.action = greedy_action(cur_state, best_next);
        end
        last_act = res.action;
      end
      tqla_pkg::FUNC_UPDATE: begin
        pos = {cur_state, last_act};
        old_v = longint'(q_table[pos]);
        if (learn_en) begin
          void'(greedy_action(r.nxt, best_next));
          target = longint'($signed(r.reward)) + scale_frac(best_next, gamma);
          nv = clamp32(old_v + scale_frac(target - old_v, alpha));
          q_table[pos] = nv[31:0];
        end else begin
          nv = old_v;
        end
        res.new_value = nv[31:0];
        cur_state = r.nxt;
      end
      tqla_pkg::FUNC_RESTART: begin
        foreach (q_table[i]) q_table[i] = fill_value;
        cur_state = start_st;
      end
      default: ;
    endcase
    res.best_action = greedy_action(cur_state, best_next);
    res.state_now = cur_state;
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic send_request(request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, r};
    do @(posedge clk); while (!in_tready);
    predict_step(r);
  endtask

  // drop valid and hold until every predicted result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tqla_pkg::REG_ALPHA:   alpha = value[15:0];
      tqla_pkg::REG_GAMMA:   gamma = value[15:0];
      tqla_pkg::REG_EPSILON: epsilon = value[15:0];
      tqla_pkg::REG_ACTIONS: actions_used = value[4:0];
      tqla_pkg::REG_LEARN:   learn_en = value[0];
      tqla_pkg::REG_INIT:    fill_value = value;
      tqla_pkg::REG_START:   start_st = value[7:0];
      default: ;
    endcase
  endtask

  function automatic request_t make_req(logic [1:0] f, logic [31:0] rw, logic [7:0] ns,
                                        logic [15:0] dr, logic [15:0] pk);
    request_t r;
    r.func = f; r.reward = rw; r.nxt = ns; r.draw = dr; r.pick = pk;
    return r;
  endfunction

  function automatic request_t random_req(bit restarts);
    request_t r;
    int w;
    r = request_t'(74'({$urandom, $urandom, $urandom}));
    w = $urandom_range(0, 99);
    if (w < 48) r.func = tqla_pkg::FUNC_ACT;
    else if (w < 94) r.func = tqla_pkg::FUNC_UPDATE;
    else if (w < 96 && restarts) r.func = tqla_pkg::FUNC_RESTART;
    else if (w < 98) r.func = tqla_pkg::FUNC_UNUSED;
    else r.func = tqla_pkg::FUNC_ACT;
    // keep states clustered so learned values get revisited
    if ($urandom_range(0, 3) != 0) r.nxt = 8'($urandom_range(0, 7));
    if ($urandom_range(0, 2) != 0) r.reward = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    return r;
  endfunction

  task automatic test_directed();
    write_reg(tqla_pkg::REG_START, 32'd3);
    send_request(make_req(tqla_pkg::FUNC_RESTART, '0, '0, '0, '0));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'hffff, 16'h0));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h7fffffff, 8'd255, '0, '0));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'h0, 16'hffff));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h80000000, 8'd0, '0, '0));
    send_request(make_req(tqla_pkg::FUNC_UNUSED, 32'hffffffff, 8'hff, 16'hffff, 16'hffff));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'd6553, 16'd7));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'd6554, 16'd7));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h00010000, 8'd3, '0, '0));
    wait_idle();
    // saturation high: alpha just below one, big fill, big reward
    write_reg(tqla_pkg::REG_ALPHA, 32'hffff);
    write_reg(tqla_pkg::REG_GAMMA, 32'hffff);
    write_reg(tqla_pkg::REG_INIT, 32'h7fffffff);
    write_reg(tqla_pkg::REG_START, 32'd255);
    send_request(make_req(tqla_pkg::FUNC_RESTART, '0, '0, '0, '0));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'hffff, '0));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h7fffffff, 8'd255, '0, '0));
    wait_idle();
    // saturation low
    write_reg(tqla_pkg::REG_INIT, 32'h80000000);
    write_reg(tqla_pkg::REG_START, 32'd0);
    send_request(make_req(tqla_pkg::FUNC_RESTART, '0, '0, '0, '0));
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'hffff, '0));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h80000000, 8'd0, '0, '0));
    wait_idle();
    // learning off, odd action counts, always explore
    write_reg(tqla_pkg::REG_LEARN, 32'd0);
    write_reg(tqla_pkg::REG_ACTIONS, 32'd0);
    write_reg(tqla_pkg::REG_EPSILON, 32'hffff);
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'hfffe, 16'hffff));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h12345678, 8'd1, '0, '0));
    wait_idle();
    write_reg(tqla_pkg::REG_ACTIONS, 32'd31);
    write_reg(tqla_pkg::REG_LEARN, 32'd1);
    write_reg(tqla_pkg::REG_EPSILON, 32'h0);
    send_request(make_req(tqla_pkg::FUNC_ACT, '0, '0, 16'h0, 16'hffff));
    send_request(make_req(tqla_pkg::FUNC_UPDATE, 32'h0, 8'd2, '0, '0));
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [31:0] init_pick [4];
    init_pick = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h0};
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(tqla_pkg::REG_ALPHA, ph == 0 ? 32'h0 : ph == 1 ? 32'hffff : $urandom);
      write_reg(tqla_pkg::REG_GAMMA, ph == 2 ? 32'h0 : ph == 3 ? 32'hffff : $urandom);
      write_reg(tqla_pkg::REG_EPSILON,
                ph == 4 ? 32'h0 : ph == 5 ? 32'hffff : $urandom_range(0, 32768));
      write_reg(tqla_pkg::REG_ACTIONS, ph == 0 ? 32'd1 : ph == 1 ? 32'd17 : $urandom);
      write_reg(tqla_pkg::REG_LEARN, ph == 2 ? 32'h0 : $urandom | 32'd1);
      write_reg(tqla_pkg::REG_INIT, ph < 4 ? init_pick[ph] : $urandom);
      write_reg(tqla_pkg::REG_START, ph == 1 ? 32'hff : $urandom);
      no_idle = (ph == 3);
      send_request(make_req(tqla_pkg::FUNC_RESTART, '0, '0, '0, '0));
      for (int i = 0; i < 110; i++) send_request(random_req(1));
    end
    no_idle = 0;
    wait_idle();
    write_reg(tqla_pkg::REG_ALPHA, 32'd6554);
    write_reg(tqla_pkg::REG_GAMMA, 32'd58982);
    write_reg(tqla_pkg::REG_EPSILON, 32'd6554);
    write_reg(tqla_pkg::REG_ACTIONS, 32'd16);
    write_reg(tqla_pkg::REG_LEARN, 32'd1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_request(random_req(0));
    // pause until the agent has drained, then resume
    wait_idle();
    for (int i = 0; i < 40; i++) send_request(random_req(0));
    wait_idle();
  endtask

  // result side: random stalls, one long hold when requested
  initial begin
    agent_result_t got, exp_r;
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = agent_result_t'(out_tdata[48:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.action !== exp_r.action) begin
          $display("%0t: action exp %0d got %0d", $time, exp_r.action, got.action);
          errors++;
        end
        if (got.best_action !== exp_r.best_action) begin
          $display("%0t: best_action exp %0d got %0d", $time, exp_r.best_action,
                   got.best_action);
          errors++;
        end
        if (got.explored !== exp_r.explored) begin
          $display("%0t: explored exp %0d got %0d", $time, exp_r.explored, got.explored);
          errors++;
        end
        if (got.new_value !== exp_r.new_value) begin
          $display("%0t: new_value exp %h got %h", $time, exp_r.new_value, got.new_value);
          errors++;
        end
        if (got.state_now !== exp_r.state_now) begin
          $display("%0t: state_now exp %0d got %0d", $time, exp_r.state_now,
                   got.state_now);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    alpha = 16'd6554;
    gamma = 16'd58982;
    epsilon = 16'd6554;
    actions_used = 5'd16;
    learn_en = 1'b1;
    fill_value = '0;
    start_st = '0;
    cur_state = '0;
    last_act = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/tqla_pkg.sv
src/tabular_q_learning_agent_core.sv
bench/tabular_q_learning_agent_core_tb.sv
